>>> rtl/sphp_pkg.sv
// shared types, constants and the quarter-wave sine table builder
package sphp_pkg;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [23:0] frame_position;
    logic [15:0] base_hue;
    logic [15:0] lightness;
  } pixel_t;

  localparam logic [13:0] ANGLE_STEP_RESET = 14'd819;
  localparam logic [17:0] RAD_TO_TURN_K    = 18'd166886;
  localparam logic [13:0] POS_LOW_K        = 14'd11215;
  localparam logic [16:0] POS_HIGH_K       = 17'd112147;
  localparam logic [17:0] POS_DIV_K        = 18'd210250;
  localparam logic [23:0] RECIP_3          = 24'd5592406;
  localparam logic [19:0] DIV_BIAS         = 20'd786432;
  localparam logic [33:0] HUE_HALF         = 34'd24576;
  localparam logic [63:0] PI_HALF_Q30      = 64'd1686629713;

  // taylor series of sin over the first quarter turn, q0.15 result
  function automatic logic [14:0] quarter_rom(input int unsigned i, input int unsigned b);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    t = (64'(i) * PI_HALF_Q30) >> b;
    t2 = (t * t) >> 30;
    term = t;
    sum = t;
    for (int k = 1; k <= 5; k++) begin
      term = (term * t2) >> 30;
      case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        default: term = term / 64'd110;
      endcase
      if (k[0]) sum = (sum >= term) ? sum - term : 64'd0;
      else sum = sum + term;
    end
    e = (sum * 64'd32767 + 64'd536870912) >> 30;
    if (e > 64'd32767) e = 64'd32767;
    return e[14:0];
  endfunction

endpackage

>>> rtl/sphp_front.sv
// front end: takes pixel commands into a two-entry queue
module sphp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sphp_pkg::pixel_t in_item,
  output logic           busy,
  output logic           out_valid,
  output sphp_pkg::pixel_t out_item
);
  import sphp_pkg::*;

  pixel_t     slot [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  // back end never stalls, so any queued beat leaves at once
  assign pop       = (count != 2'd0);
  assign out_valid = pop;
  assign out_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/sphp_sine.sv
// quarter-wave table sine lookup with registered q1.15 output
module sphp_sine #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic [15:0]        angle,
  output logic signed [15:0] sine
);
  import sphp_pkg::*;

  localparam int B = SINE_TABLE_BITS;

  logic [14:0]  rom [0:(1 << B)];
  logic [B-1:0] idx;
  logic [B:0]   idx_m;
  logic [15:0]  mag;

  for (genvar gi = 0; gi <= (1 << B); gi++) begin : g_rom
    assign rom[gi] = quarter_rom(gi, B);
  end

  assign idx   = angle[13:14-B];
  // odd quadrants run the table backwards
  assign idx_m = angle[14] ? ((B+1)'(1 << B) - {1'b0, idx}) : {1'b0, idx};
  assign mag   = {1'b0, rom[idx_m]};

  always_ff @(posedge clk) begin
    sine <= angle[15] ? -$signed(mag) : $signed(mag);
  end

endmodule

>>> rtl/sphp_back.sv
// back end: ten-stage pipeline from pixel to rgb
module sphp_back #(
  parameter int MAX_DIM         = 1024,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sphp_pkg::pixel_t in_item,
  input  logic [13:0]      step,
  output logic             strobe,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);
  import sphp_pkg::*;

  localparam logic [9:0] COORD_MAX = (MAX_DIM > 1024) ? 10'd1023 : 10'(MAX_DIM - 1);

  logic [9:0]  vld;
  logic [15:0] hue_d   [0:6];
  logic [15:0] light_d [0:6];

  // stage 1
  logic [9:0]  xc, yc;
  logic [24:0] xs, ys;
  logic [37:0] pl_p;
  logic [40:0] ph_p;
  logic [41:0] pd_p;
  // stage 2
  logic [42:0] xm, ym;
  logic [15:0] pl, ph;
  logic [16:0] pd;
  // stage 3
  logic [42:0] xr, yr;
  logic [16:0] xa, ya, t3;
  logic [15:0] ax, ay, apl, aph, a3;
  // stage 4
  logic signed [15:0] sx, sy, spl, sph, s3;
  // stage 5
  logic signed [31:0] p1, p2;
  logic signed [15:0] s3_d;
  // stage 6
  logic signed [33:0] s_sum, num;
  logic signed [19:0] tq;
  logic [19:0] u;
  // stage 7
  logic [43:0] uq;
  logic [15:0] hq;
  // stage 8
  logic [15:0] h;
  logic [18:0] h6;
  logic [16:0] l2;
  logic [15:0] mx_n, mn_n;
  logic [2:0]  sec;
  logic [15:0] f, mx, mn, c;
  // stage 9
  logic [31:0] rp;
  logic [32:0] fp;
  logic [16:0] rise, fall;
  logic [15:0] mx9, mn9;
  logic [2:0]  sec9;
  // stage 10
  logic [16:0] r_v, g_v, b_v;

  function automatic logic [7:0] to8(input logic [16:0] v);
    logic [15:0] vc;
    logic [23:0] n;
    logic [24:0] q;
    vc = (v > 17'd65535) ? 16'hFFFF : v[15:0];
    n = 24'(vc) * 24'd255 + 24'd32767;
    // floor divide by 65535
    q = 25'(n) + 25'(n >> 16) + 25'd1;
    return q[23:16];
  endfunction

  assign xc = (in_item.pixel_x > COORD_MAX) ? COORD_MAX : in_item.pixel_x;
  assign yc = (in_item.pixel_y > COORD_MAX) ? COORD_MAX : in_item.pixel_y;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[8:0], in_valid};
  end

  always_ff @(posedge clk) begin
    hue_d[0]   <= in_item.base_hue;
    light_d[0] <= in_item.lightness;
    for (int i = 1; i < 7; i++) begin
      hue_d[i]   <= hue_d[i-1];
      light_d[i] <= light_d[i-1];
    end
  end

  // angle products
  always_ff @(posedge clk) begin
    xs   <= (11'(xc) + 11'd1) * step;
    ys   <= (11'(yc) + 11'd1) * step;
    pl_p <= in_item.frame_position * POS_LOW_K;
    ph_p <= in_item.frame_position * POS_HIGH_K;
    pd_p <= in_item.frame_position * POS_DIV_K;
  end

  always_ff @(posedge clk) begin
    xm <= 43'(xs) * 43'(RAD_TO_TURN_K);
    ym <= 43'(ys) * 43'(RAD_TO_TURN_K);
    pl <= 16'((pl_p + 38'd32768) >> 16);
    ph <= 16'((ph_p + 41'd32768) >> 16);
    pd <= 17'((pd_p + 42'd32768) >> 16);
  end

  assign xr = xm + 43'd32768;
  assign yr = ym + 43'd32768;
  assign xa = xr[32:16];
  assign ya = yr[32:16];
  assign t3 = xa + ya + pd;

  always_ff @(posedge clk) begin
    ax  <= xa[15:0];
    ay  <= ya[15:0];
    apl <= pl;
    aph <= ph;
    a3  <= t3[16:1];
  end

  sphp_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sx  (.clk(clk), .angle(ax),  .sine(sx));
  sphp_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sy  (.clk(clk), .angle(ay),  .sine(sy));
  sphp_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_spl (.clk(clk), .angle(apl), .sine(spl));
  sphp_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sph (.clk(clk), .angle(aph), .sine(sph));
  sphp_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_s3  (.clk(clk), .angle(a3),  .sine(s3));

  always_ff @(posedge clk) begin
    p1   <= sx * spl;
    p2   <= sy * sph;
    s3_d <= s3;
  end

  // s/3 rounded: floor((s + half) / 49152) via a biased divide by three
  assign s_sum = 34'(p1) - 34'(p2) + (34'(s3_d) <<< 15);
  assign num   = s_sum + $signed(HUE_HALF);
  assign tq    = 20'(num >>> 14);

  always_ff @(posedge clk) begin
    u <= $unsigned(tq) + DIV_BIAS;
  end

  assign uq = 44'(u) * 44'(RECIP_3);

  always_ff @(posedge clk) begin
    hq <= uq[39:24];
  end

  // bias removal vanishes mod one turn
  assign h    = hue_d[6] + hq;
  assign h6   = 19'(h) * 19'd6;
  assign l2   = {light_d[6], 1'b0};
  assign mx_n = (l2 > 17'd65535) ? 16'hFFFF : l2[15:0];
  assign mn_n = (l2 > 17'd65535) ? 16'(l2 - 17'd65535) : 16'd0;

  always_ff @(posedge clk) begin
    sec <= h6[18:16];
    f   <= h6[15:0];
    mx  <= mx_n;
    mn  <= mn_n;
    c   <= mx_n - mn_n;
  end

  assign rp = c * f;
  assign fp = 33'(c) * (33'd65536 - 33'(f));

  always_ff @(posedge clk) begin
    rise <= 17'(mn) + 17'((33'(rp) + 33'd32768) >> 16);
    fall <= 17'(mn) + 17'((fp + 33'd32768) >> 16);
    mx9  <= mx;
    mn9  <= mn;
    sec9 <= sec;
  end

  always_comb begin
    case (sec9)
      3'd0: begin r_v = 17'(mx9); g_v = rise;     b_v = 17'(mn9); end
      3'd1: begin r_v = fall;     g_v = 17'(mx9); b_v = 17'(mn9); end
      3'd2: begin r_v = 17'(mn9); g_v = 17'(mx9); b_v = rise;     end
      3'd3: begin r_v = 17'(mn9); g_v = fall;     b_v = 17'(mx9); end
      3'd4: begin r_v = rise;     g_v = 17'(mn9); b_v = 17'(mx9); end
      default: begin r_v = 17'(mx9); g_v = 17'(mn9); b_v = fall; end
    endcase
  end

  always_ff @(posedge clk) begin
    red   <= to8(r_v);
    green <= to8(g_v);
    blue  <= to8(b_v);
  end

  assign strobe = vld[9];

`ifndef NO_ASSERTIONS
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe right after reset");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##10 strobe)
    else $error("beat lost in pipeline");
  a_sector: assert property (@(posedge clk) disable iff (rst)
    vld[8] |-> (sec9 != 3'd6 && sec9 != 3'd7))
    else $error("hue sector out of range");
`endif

endmodule

>>> rtl/sine_plasma_hue_pixel_generator_unit.sv
// top level of the sine plasma hue pixel generator
// usage:
//   pulse start with pixel_x, pixel_y, frame_position, base_hue and lightness;
//   the beat is taken at a clock edge where start is high and busy is low.
//   a front queue of two entries feeds a ten-stage back pipeline.
//   one pixel per clock is sustained; busy stays low in normal use since
//   the pipeline drains the queue every cycle.
//   the accepting edge writes the beat into a queue slot; from there it
//   passes pipeline stages one to ten in turn, stage ten driving the
//   result ports and strobe (the five sine lookups sit in stage four).
//   red, green and blue are valid for the one cycle that strobe is high;
//   the receiver cannot stall, so results are never held.
//   angle_step is written with angle_step_we; the user writes it only while
//   no pixel is in flight, the block has no check of this. reset (rst,
//   synchronous) empties the queue and pipeline and loads angle_step with 819.
module sine_plasma_hue_pixel_generator_unit #(
  parameter int MAX_DIM         = 1024,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  pixel_x,
  input  logic [9:0]  pixel_y,
  input  logic [23:0] frame_position,
  input  logic [15:0] base_hue,
  input  logic [15:0] lightness,
  input  logic        angle_step_we,
  input  logic [13:0] angle_step,
  output logic        strobe,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import sphp_pkg::*;

  pixel_t      in_item;
  pixel_t      q_item;
  logic        q_valid;
  logic [13:0] step;

  assign in_item = '{pixel_x: pixel_x, pixel_y: pixel_y, frame_position: frame_position,
                     base_hue: base_hue, lightness: lightness};

  always_ff @(posedge clk) begin
    if (rst) step <= ANGLE_STEP_RESET;
    else if (angle_step_we) step <= angle_step;
  end

  sphp_front u_front (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .out_valid(q_valid), .out_item(q_item)
  );

  sphp_back #(.MAX_DIM(MAX_DIM), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_item(q_item), .step(step),
    .strobe(strobe), .red(red), .green(green), .blue(blue)
  );

endmodule
